// ----- src/spi_master_shift_engine_assert.svh -----
// ---------------------------------------------------------------------------
// SPI master shift engine assertion macros
// Concurrent assertion wrappers used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SPI_MASTER_SHIFT_ENGINE_ASSERT_SVH
`define SPI_MASTER_SHIFT_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SMSE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SMSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/smse_pkg.sv -----
// ---------------------------------------------------------------------------
// SPI master shift engine package
// Widths, command and register codes, result type and word size helpers.
// ---------------------------------------------------------------------------
package smse_pkg;

   localparam int WORD_W        = 32;
   localparam int MAX_WORD_BITS = 32;
   localparam int COUNT_W       = 6;
   localparam int CMD_W         = 3;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 2;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 40;

   localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SEL_ON   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEL_OFF  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] REG_CLOCK_IDLE_HIGH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SELECT_HIGH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_FIRST    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_WORD_SIZE       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_AUTO_SELECT     = 3'd4;

   localparam logic [1:0] SIZE_8  = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;

   typedef struct packed {
      logic              sck_level;
      logic              sdo_level;
      logic              select_level;
      logic              busy_res;
      logic              done_res;
      logic [WORD_W-1:0] rx_word;
   } result_type;

   function automatic logic [COUNT_W-1:0] word_bits(input logic [1:0] code);
      logic [COUNT_W-1:0] n;
      case (code)
         SIZE_8:  n = COUNT_W'(8);
         SIZE_16: n = COUNT_W'(16);
         default: n = COUNT_W'(32);
      endcase
      if (n > COUNT_W'(MAX_WORD_BITS)) begin
         n = COUNT_W'(MAX_WORD_BITS);
      end
      return n;
   endfunction

   function automatic logic [WORD_W-1:0] word_mask(input logic [1:0] code);
      logic [COUNT_W-1:0] sh;
      sh = COUNT_W'(WORD_W) - word_bits(code);
      return {WORD_W{1'b1}} >> sh;
   endfunction

   function automatic logic tx_bit(input logic [WORD_W-1:0] w,
                                   input logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] idx;
      idx = n - COUNT_W'(1);
      if (n == '0 || n > COUNT_W'(WORD_W)) begin
         return 1'b0;
      end
      return w[idx[4:0]];
   endfunction

endpackage

// ----- src/smse_out_buf.sv -----
// ---------------------------------------------------------------------------
// SPI master shift engine result buffer
// Two-entry output register with skid stage so the engine can still accept
// while one result waits on the downstream side.
// ---------------------------------------------------------------------------
module smse_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  smse_pkg::result_type push_data,
   output logic                push_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output smse_pkg::result_type out_data
);
   import smse_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop        = main_valid_ff & out_ready;
   assign push_ready = ~skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ----- src/spi_master_shift_engine.sv -----
// ---------------------------------------------------------------------------
// SPI master shift engine
// Results are formed combinationally and registered in the result buffer.
// Throughput: one request beat per cycle while the result buffer has room;
// the engine state updates in the accepting cycle, and a two-entry result
// buffer absorbs downstream stalls. Reset: synchronous; the shifter is idle,
// SCK and SDO low, select inactive, mode 1, 8-bit words, automatic select.
// ---------------------------------------------------------------------------
module spi_master_shift_engine (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: tx_word[31:0], sdi_level[32], zero fill [39:33]
   input  logic [smse_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: command[2:0]
   input  logic [smse_pkg::CMD_W-1:0]          req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: sck_level[0], sdo_level[1], select_level[2], busy_res[3],
   //        rx_word[35:4], zero fill [39:36]
   output logic [smse_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: done_res[0]
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [smse_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [smse_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import smse_pkg::*;

   logic               clock_idle_ff;
   logic               select_high_ff;
   logic               sample_first_ff;
   logic [1:0]         word_size_ff;
   logic               auto_select_ff;

   logic [WORD_W-1:0]  tx_shift_ff, tx_shift_in;
   logic [WORD_W-1:0]  rx_shift_ff, rx_shift_in;
   logic [COUNT_W-1:0] bits_left_ff, bits_left_in;
   logic               half_phase_ff, half_phase_in;
   logic               shifting_ff, shifting_in;
   logic               sck_ff, sck_in;
   logic               sdo_ff, sdo_in;
   logic               select_on_ff, select_on_in;

   logic               accept;
   logic [CMD_W-1:0]   cmd;
   logic [WORD_W-1:0]  tx_word;
   logic               sdi;
   logic [COUNT_W-1:0] bits_dec;
   logic [COUNT_W-1:0] start_bits;
   logic [WORD_W-1:0]  start_word;
   logic               done;
   logic [WORD_W-1:0]  rx_word;
   result_type         result;
   result_type         out_data;

   assign accept  = req_tvalid & req_tready;
   assign cmd     = req_tuser;
   assign tx_word = req_tdata[WORD_W-1:0];
   assign sdi     = req_tdata[WORD_W];

   always_comb begin
      tx_shift_in   = tx_shift_ff;
      rx_shift_in   = rx_shift_ff;
      bits_left_in  = bits_left_ff;
      half_phase_in = half_phase_ff;
      shifting_in   = shifting_ff;
      sck_in        = sck_ff;
      sdo_in        = sdo_ff;
      select_on_in  = select_on_ff;
      done          = 1'b0;
      rx_word       = '0;
      bits_dec      = (bits_left_ff == '0) ? '0 : bits_left_ff - COUNT_W'(1);
      start_bits    = word_bits(word_size_ff);
      start_word    = tx_word & word_mask(word_size_ff);
      if (accept) begin
         unique case (cmd)
            CMD_TICK: begin
               if (shifting_ff) begin
                  if (!half_phase_ff) begin
                     sck_in = ~clock_idle_ff;
                     if (sample_first_ff) begin
                        rx_shift_in = {rx_shift_ff[WORD_W-2:0], sdi};
                     end else begin
                        sdo_in = tx_bit(tx_shift_ff, bits_left_ff);
                     end
                     half_phase_in = 1'b1;
                  end else begin
                     sck_in = clock_idle_ff;
                     if (!sample_first_ff) begin
                        rx_shift_in = {rx_shift_ff[WORD_W-2:0], sdi};
                     end
                     half_phase_in = 1'b0;
                     bits_left_in  = bits_dec;
                     if (bits_dec == '0) begin
                        shifting_in = 1'b0;
                        done        = 1'b1;
                        rx_word     = rx_shift_in & word_mask(word_size_ff);
                        if (auto_select_ff) begin
                           select_on_in = 1'b0;
                        end
                     end else if (sample_first_ff) begin
                        sdo_in = tx_bit(tx_shift_ff, bits_dec);
                     end
                  end
               end
            end
            CMD_START: begin
               if (!shifting_ff) begin
                  tx_shift_in   = start_word;
                  rx_shift_in   = '0;
                  bits_left_in  = start_bits;
                  half_phase_in = 1'b0;
                  shifting_in   = 1'b1;
                  sck_in        = clock_idle_ff;
                  if (auto_select_ff) begin
                     select_on_in = 1'b1;
                  end
                  if (sample_first_ff) begin
                     sdo_in = tx_bit(start_word, start_bits);
                  end
               end
            end
            CMD_SEL_ON: select_on_in = 1'b1;
            CMD_SEL_OFF: select_on_in = 1'b0;
            CMD_RELEASE: begin
               shifting_in   = 1'b0;
               bits_left_in  = '0;
               half_phase_in = 1'b0;
               sck_in        = clock_idle_ff;
               sdo_in        = 1'b0;
               select_on_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      result.sck_level    = sck_in;
      result.sdo_level    = sdo_in;
      result.select_level = select_on_in ? select_high_ff : ~select_high_ff;
      result.busy_res     = shifting_in;
      result.done_res     = done;
      result.rx_word      = rx_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_idle_ff   <= 1'b0;
         select_high_ff  <= 1'b0;
         sample_first_ff <= 1'b0;
         word_size_ff    <= SIZE_8;
         auto_select_ff  <= 1'b1;
         tx_shift_ff     <= '0;
         rx_shift_ff     <= '0;
         bits_left_ff    <= '0;
         half_phase_ff   <= 1'b0;
         shifting_ff     <= 1'b0;
         sck_ff          <= 1'b0;
         sdo_ff          <= 1'b0;
         select_on_ff    <= 1'b0;
      end else begin
         tx_shift_ff   <= tx_shift_in;
         rx_shift_ff   <= rx_shift_in;
         bits_left_ff  <= bits_left_in;
         half_phase_ff <= half_phase_in;
         shifting_ff   <= shifting_in;
         sdo_ff        <= sdo_in;
         select_on_ff  <= select_on_in;
         if (csr_we && (csr_index == REG_CLOCK_IDLE_HIGH) && !shifting_ff) begin
            sck_ff <= csr_wdata[0];
         end else begin
            sck_ff <= sck_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               REG_CLOCK_IDLE_HIGH: clock_idle_ff <= csr_wdata[0];
               REG_SELECT_HIGH:  select_high_ff  <= csr_wdata[0];
               REG_SAMPLE_FIRST: sample_first_ff <= csr_wdata[0];
               REG_WORD_SIZE:    word_size_ff    <= csr_wdata;
               REG_AUTO_SELECT:  auto_select_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   smse_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (result),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_data)
   );

   assign rsp_tdata = {4'b0000, out_data.rx_word, out_data.busy_res,
                       out_data.select_level, out_data.sdo_level,
                       out_data.sck_level};
   assign rsp_tuser = out_data.done_res;

`include "spi_master_shift_engine_assert.svh"

   `SMSE_ASSERT_NOW(a_idle_no_bits, !shifting_ff, bits_left_ff == '0, "idle with bits left")
   `SMSE_ASSERT_NOW(a_busy_has_bits, shifting_ff, bits_left_ff != '0, "busy with no bits left")
   `SMSE_ASSERT_NOW(a_half_in_shift, half_phase_ff, shifting_ff, "half phase set while idle")
   `SMSE_ASSERT_NEXT(a_done_ends_busy, accept && done, !shifting_ff, "shifter busy after done")

endmodule

// ----- sim/spi_master_shift_engine_tb.sv -----
// ---------------------------------------------------------------------------
// SPI master shift engine testbench
// Drives command and tick beats into the engine under random source and sink
// gaps. A cycle-level model of the shifter in this bench predicts the pin
// levels, busy, done and received word for every beat, and the scoreboard
// compares each result beat field by field. Settings are swept through all
// clock modes, word sizes and select options, including changes made while a
// word is still shifting.
// ---------------------------------------------------------------------------
module spi_master_shift_engine_tb;
   import smse_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                    clock;
   logic                    reset;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic [CMD_W-1:0]        req_tuser;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic                    csr_we;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   spi_master_shift_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Settings mirrored by the bench.
   logic              cpol;
   logic              ss_high;
   logic              cpha_first;
   logic [1:0]        size_code;
   logic              auto_ss;

   // Shifter state mirrored by the bench.
   logic [WORD_W-1:0] tx_sh;
   logic [WORD_W-1:0] rx_sh;
   logic [COUNT_W-1:0] bits_todo;
   logic              half;
   logic              shifting;
   logic              sck_q;
   logic              sdo_q;
   logic              ss_on;

   result_type        pending_pins[$];
   result_type        want;
   int                mismatches;
   int                beats_sent;
   int                cycle_count;
   int                stall_request;
   bit                sender_gaps;
   bit                receiver_gaps;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic [COUNT_W-1:0] exchange_len(input logic [1:0] code);
      logic [COUNT_W-1:0] n;
      case (code)
         SIZE_8:  n = COUNT_W'(8);
         SIZE_16: n = COUNT_W'(16);
         default: n = COUNT_W'(32);
      endcase
      if (n > COUNT_W'(MAX_WORD_BITS)) begin
         n = COUNT_W'(MAX_WORD_BITS);
      end
      return n;
   endfunction

   function automatic logic [WORD_W-1:0] len_mask(input logic [COUNT_W-1:0] n);
      if (n >= COUNT_W'(WORD_W)) begin
         return '1;
      end
      return (WORD_W'(1) << n) - WORD_W'(1);
   endfunction

   function automatic logic next_tx_bit();
      logic [COUNT_W-1:0] pos;
      pos = bits_todo - COUNT_W'(1);
      if (bits_todo == '0 || bits_todo > COUNT_W'(WORD_W)) begin
         return 1'b0;
      end
      return tx_sh[pos[4:0]];
   endfunction

   task automatic reset_model();
      cpol       = 1'b0;
      ss_high    = 1'b0;
      cpha_first = 1'b0;
      size_code  = SIZE_8;
      auto_ss    = 1'b1;
      tx_sh      = '0;
      rx_sh      = '0;
      bits_todo  = '0;
      half       = 1'b0;
      shifting   = 1'b0;
      sck_q      = 1'b0;
      sdo_q      = 1'b0;
      ss_on      = 1'b0;
   endtask

   task automatic apply_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      case (index)
         REG_CLOCK_IDLE_HIGH: begin
            cpol = value[0];
            if (!shifting) begin
               sck_q = cpol;
            end
         end
         REG_SELECT_HIGH:  ss_high = value[0];
         REG_SAMPLE_FIRST: cpha_first = value[0];
         REG_WORD_SIZE:    size_code = value;
         REG_AUTO_SELECT:  auto_ss = value[0];
         default: ;
      endcase
   endtask

   task automatic engine_step(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] tx,
                              input logic sdi, output result_type r);
      logic              done_now;
      logic [WORD_W-1:0] rx_out;
      logic [COUNT_W-1:0] n;
      done_now = 1'b0;
      rx_out   = '0;
      case (cmd)
         CMD_TICK: begin
            if (shifting) begin
               if (!half) begin
                  sck_q = ~cpol;
                  if (cpha_first) begin
                     rx_sh = {rx_sh[WORD_W-2:0], sdi};
                  end else begin
                     sdo_q = next_tx_bit();
                  end
                  half = 1'b1;
               end else begin
                  sck_q = cpol;
                  if (!cpha_first) begin
                     rx_sh = {rx_sh[WORD_W-2:0], sdi};
                  end
                  half = 1'b0;
                  if (bits_todo != '0) begin
                     bits_todo--;
                  end
                  if (bits_todo == '0) begin
                     shifting = 1'b0;
                     done_now = 1'b1;
                     rx_out   = rx_sh & len_mask(exchange_len(size_code));
                     if (auto_ss) begin
                        ss_on = 1'b0;
                     end
                  end else if (cpha_first) begin
                     sdo_q = next_tx_bit();
                  end
               end
            end
         end
         CMD_START: begin
            if (!shifting) begin
               n         = exchange_len(size_code);
               tx_sh     = tx & len_mask(n);
               rx_sh     = '0;
               bits_todo = n;
               half      = 1'b0;
               shifting  = 1'b1;
               sck_q     = cpol;
               if (auto_ss) begin
                  ss_on = 1'b1;
               end
               if (cpha_first) begin
                  sdo_q = next_tx_bit();
               end
            end
         end
         CMD_SEL_ON:  ss_on = 1'b1;
         CMD_SEL_OFF: ss_on = 1'b0;
         CMD_RELEASE: begin
            shifting  = 1'b0;
            bits_todo = '0;
            half      = 1'b0;
            sck_q     = cpol;
            sdo_q     = 1'b0;
            ss_on     = 1'b0;
         end
         default: ;
      endcase
      r.sck_level    = sck_q;
      r.sdo_level    = sdo_q;
      r.select_level = ss_on ? ss_high : ~ss_high;
      r.busy_res     = shifting;
      r.done_res     = done_now;
      r.rx_word      = rx_out;
   endtask

   task automatic check_field(input string field, input logic [WORD_W-1:0] exp_val,
                              input logic [WORD_W-1:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0h, actual %0h", field, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : result_check
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pins.size() == 0) begin
            $error("result beat with no prediction waiting");
            mismatches++;
         end else begin
            want = pending_pins.pop_front();
            check_field("sck_level", WORD_W'(want.sck_level), WORD_W'(rsp_tdata[0]));
            check_field("sdo_level", WORD_W'(want.sdo_level), WORD_W'(rsp_tdata[1]));
            check_field("select_level", WORD_W'(want.select_level),
                        WORD_W'(rsp_tdata[2]));
            check_field("busy_res", WORD_W'(want.busy_res), WORD_W'(rsp_tdata[3]));
            check_field("rx_word", want.rx_word, rsp_tdata[35:4]);
            check_field("done_res", WORD_W'(want.done_res), WORD_W'(rsp_tuser));
         end
      end
   end

   initial begin : result_sink
      int wait_n;
      int hold_n;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         hold_n        = stall_request;
         stall_request = 0;
         wait_n        = receiver_gaps ? $urandom_range(0, 7) : 0;
         if (hold_n + wait_n > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_n + wait_n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] tx,
                            input logic sdi);
      int gap;
      result_type r;
      gap = sender_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'b0, sdi, tx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      engine_step(cmd, tx, sdi, r);
      pending_pins.push_back(r);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_pins.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_step(input logic [CSR_INDEX_W-1:0] index,
                           input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      apply_reg(index, value);
      @(negedge clock);
   endtask

   task automatic configure(input logic idle_hi, input logic sel_hi, input logic first,
                            input logic [1:0] code, input logic auto_on);
      csr_step(REG_CLOCK_IDLE_HIGH, {1'b0, idle_hi});
      csr_step(REG_SELECT_HIGH, {1'b0, sel_hi});
      csr_step(REG_SAMPLE_FIRST, {1'b0, first});
      csr_step(REG_WORD_SIZE, code);
      csr_step(REG_AUTO_SELECT, {1'b0, auto_on});
      csr_step(CSR_INDEX_W'($urandom_range(5, 7)), CSR_DATA_W'($urandom_range(0, 3)));
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_exchange();
      int n;
      n = int'(exchange_len(size_code));
      if (!auto_ss) begin
         send_beat(CMD_SEL_ON, $urandom, 1'($urandom_range(0, 1)));
      end
      send_beat(CMD_START, pick_word(), 1'($urandom_range(0, 1)));
      for (int i = 0; i < 2 * n; i++) begin
         if ($urandom_range(0, 39) == 0) begin
            send_beat(CMD_W'($urandom_range(1, 7)), $urandom, 1'($urandom_range(0, 1)));
         end
         send_beat(CMD_TICK, $urandom, 1'($urandom_range(0, 1)));
      end
      if (!auto_ss) begin
         send_beat(CMD_SEL_OFF, $urandom, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic random_traffic(input int count);
      int stop_at;
      stop_at = beats_sent + count;
      while (beats_sent < stop_at) begin
         if ($urandom_range(0, 9) < 7) begin
            run_exchange();
         end else begin
            send_beat(CMD_W'($urandom_range(0, 7)), $urandom, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic test_idle_commands();
      send_beat(CMD_W'(7), '1, 1'b1);
      send_beat(CMD_RELEASE, '0, 1'b0);
   endtask

   task automatic test_directed_exchange();
      send_beat(CMD_START, '1, 1'b0);
      send_beat(CMD_START, '0, 1'b1);
      for (int i = 0; i < 4; i++) begin
         send_beat(CMD_TICK, '0, i[1]);
      end
      send_beat(CMD_SEL_OFF, '0, 1'b0);
      send_beat(CMD_SEL_ON, '0, 1'b0);
      for (int i = 4; i < 16; i++) begin
         send_beat(CMD_TICK, '1, i[1]);
      end
      send_beat(CMD_TICK, '0, 1'b1);
      send_beat(CMD_START, 32'h0000_005A, 1'b0);
      for (int i = 0; i < 3; i++) begin
         send_beat(CMD_TICK, '0, 1'b1);
      end
      send_beat(CMD_RELEASE, '1, 1'b1);
      drain_results();
   endtask

   task automatic test_mode_sweep();
      logic [3:0] p;
      for (int k = 0; k < 16; k++) begin
         p = 4'(k);
         if (p[0]) begin
            send_beat(CMD_START, pick_word(), 1'b1);
            for (int i = 0; i < 3; i++) begin
               send_beat(CMD_TICK, $urandom, 1'($urandom_range(0, 1)));
            end
         end
         drain_results();
         configure(p[0], p[1] ^ p[2], p[1], p[3:2], (k % 3) != 0);
         random_traffic(65);
      end
      drain_results();
   endtask

   task automatic test_backpressure();
      configure(1'b0, 1'b0, 1'b1, SIZE_8, 1'b1);
      sender_gaps   = 1'b0;
      stall_request = 80;
      random_traffic(40);
      sender_gaps = 1'b1;
      drain_results();
   endtask

   task automatic test_streaming();
      configure(1'b1, 1'b1, 1'b0, SIZE_16, 1'b0);
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      random_traffic(120);
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      drain_results();
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = CMD_TICK;
      csr_we        = 1'b0;
      csr_index     = REG_CLOCK_IDLE_HIGH;
      csr_wdata     = '0;
      mismatches    = 0;
      beats_sent    = 0;
      cycle_count   = 0;
      stall_request = 0;
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      reset_model();
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_idle_commands();
      test_directed_exchange();
      test_mode_sweep();
      test_backpressure();
      test_streaming();

      drain_results();
      repeat (10) @(posedge clock);
      if (pending_pins.size() != 0) begin
         $error("%0d predicted results never arrived", pending_pins.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
